// ===== src/txcon_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Screen geometry, field widths, character codes, request and result types
// shared by the text console modules.
// ----------------------------------------------------------------------------
package txcon_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int POS_W     = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int IN_COL_W  = 7;
  localparam int IN_ROW_W  = 5;
  localparam int OUT_POS_W = 11;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE       = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE         = 8'd32;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

  typedef enum logic [1:0] {
    REQ_PUT       = 2'd0,
    REQ_CLEAR     = 2'd1,
    REQ_BACKSPACE = 2'd2,
    REQ_READ      = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t             kind;
    logic [CHAR_W-1:0]     char_code;
    logic [ATTR_W-1:0]     attr_in;
    logic                  use_position;
    logic [IN_COL_W-1:0]   col_in;
    logic [IN_ROW_W-1:0]   row_in;
  } req_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BS_RD,
    ST_BS_WR,
    ST_RD,
    ST_RD_CAP,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  function automatic logic [POS_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
  endfunction

endpackage

// ===== src/txcon_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module txcon_ram #(
  parameter int  WIDTH  = 16,
  parameter int  DEPTH  = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/txcon_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console sequencer
// Holds the cursor and drives the screen memory: single-cell writes,
// read-modify-write for backspace, cell reads, the scroll copy and the fill sweeps.
// ----------------------------------------------------------------------------
module txcon_ctrl import txcon_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] default_attribute,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_req,
  output logic              done_valid,
  input  logic              done_ready,
  output res_t              done_res
);

  state_t             state, state_next;
  logic [POS_W-1:0]   idx, idx_next;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic [COL_W-1:0]   cur_col, cur_col_next;
  logic               copy_vld, copy_vld_next;
  logic [POS_W-1:0]   copy_dst, copy_dst_next;
  logic [CELL_W-1:0]  fill_data, fill_data_next;
  logic [CELL_W-1:0]  rd_cell, rd_cell_next;
  req_t               req;

  logic               ram_we;
  logic [POS_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [POS_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic [ROW_W-1:0]   pos_row, tgt_row;
  logic [COL_W-1:0]   pos_col, tgt_col;
  logic [POS_W-1:0]   cur_addr, tgt_addr;
  logic [ATTR_W-1:0]  attr_eff;
  logic               wrap, last_row;

  txcon_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Positions beyond the screen saturate to the last row or column.
  assign pos_row  = (req.row_in >= ROWS)    ? ROW_W'(ROWS - 1)    : ROW_W'(req.row_in);
  assign pos_col  = (req.col_in >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(req.col_in);
  assign tgt_row  = req.use_position ? pos_row : cur_row;
  assign tgt_col  = req.use_position ? pos_col : cur_col;
  assign cur_addr = cell_addr(cur_row, cur_col);
  assign tgt_addr = cell_addr(tgt_row, tgt_col);
  assign attr_eff = (req.attr_in == '0) ? default_attribute : req.attr_in;
  assign wrap     = (req.char_code == NEWLINE_CODE) || (tgt_col == COL_W'(COLUMNS - 1));
  assign last_row = (tgt_row == ROW_W'(ROWS - 1));

  assign done_res.cursor_pos = OUT_POS_W'(cur_addr);
  assign done_res.cell_char  = rd_cell[CHAR_W-1:0];
  assign done_res.cell_attr  = rd_cell[CELL_W-1:CHAR_W];

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    copy_vld_next  = 1'b0;
    copy_dst_next  = copy_dst;
    fill_data_next = fill_data;
    rd_cell_next   = rd_cell;
    ram_we         = 1'b0;
    ram_waddr      = idx;
    ram_wdata      = fill_data;
    ram_raddr      = cur_addr;
    in_ready       = 1'b0;
    done_valid     = 1'b0;

    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (idx == POS_W'(CELLS - 1)) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_cell_next = '0;
        unique case (req.kind)
          REQ_PUT: begin
            if (req.char_code != NEWLINE_CODE) begin
              ram_we    = 1'b1;
              ram_waddr = tgt_addr;
              ram_wdata = {attr_eff, req.char_code};
            end
            cur_row_next = tgt_row;
            state_next   = ST_DONE;
            if (wrap) begin
              cur_col_next = '0;
              if (last_row) begin
                idx_next   = '0;
                state_next = ST_SCROLL;
              end else begin
                cur_row_next = tgt_row + 1'b1;
              end
            end else begin
              cur_col_next = tgt_col + 1'b1;
            end
          end
          REQ_CLEAR: begin
            fill_data_next = {default_attribute, SPACE_CODE};
            idx_next       = '0;
            cur_row_next   = '0;
            cur_col_next   = '0;
            state_next     = ST_FILL;
          end
          REQ_BACKSPACE: begin
            if (cur_row == '0 && cur_col == '0) begin
              state_next = ST_DONE;
            end else begin
              if (cur_col == '0) begin
                cur_col_next = COL_W'(COLUMNS - 1);
                cur_row_next = cur_row - 1'b1;
              end else begin
                cur_col_next = cur_col - 1'b1;
              end
              state_next = ST_BS_RD;
            end
          end
          REQ_READ: begin
            state_next = ST_RD;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_BS_RD: begin
        state_next = ST_BS_WR;
      end
      ST_BS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = cur_addr;
        ram_wdata  = {ram_rdata[CELL_W-1:CHAR_W], SPACE_CODE};
        state_next = ST_DONE;
      end
      ST_RD: begin
        ram_raddr  = cell_addr(pos_row, pos_col);
        state_next = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        rd_cell_next = ram_rdata;
        state_next   = ST_DONE;
      end
      ST_SCROLL: begin
        // Read row r+1 while the word read last cycle is written into row r.
        ram_we    = copy_vld;
        ram_waddr = copy_dst;
        ram_wdata = ram_rdata;
        if (idx < POS_W'(CELLS - COLUMNS)) begin
          ram_raddr     = idx + POS_W'(COLUMNS);
          copy_vld_next = 1'b1;
          copy_dst_next = idx;
          idx_next      = idx + 1'b1;
        end else begin
          fill_data_next = '0;
          state_next     = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (idx == POS_W'(CELLS - 1)) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DONE: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      idx      <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      copy_vld <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      copy_vld <= copy_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_dst  <= copy_dst_next;
    fill_data <= fill_data_next;
    rd_cell   <= rd_cell_next;
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

`ifndef SYNTH
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROWS) && (cur_col < COLUMNS))
    else $error("cursor outside the screen");

  a_scroll_copy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL && copy_vld) |-> (ram_waddr + POS_W'(COLUMNS) == $past(ram_raddr)))
    else $error("scroll copy written to the wrong row");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ram_we)
    else $error("screen written while idle");
`endif

endmodule

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell text console with cursor, scroll, clear, backspace and
// cell read, backed by one screen memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one at a time; every request gives
//   exactly one result on the m_axis channel (cursor position after the
//   request, plus the cell contents for a cell read, zero otherwise).
//   cfg_we/cfg_wdata write the default attribute; write it only while idle.
// Sequencing: put character writes one cell; backspace reads the cell,
//   then rewrites it; cell read captures the cell; clear sweeps every cell;
//   a put character that scrolls copies each row up, then sweeps the last
//   row. The scroll and clear sweeps are paced by the single write port of
//   the screen memory: one cell a cycle. A new request is taken at the
//   earliest in the cycle after the previous result is handed on.
// Reset: the cursor homes, the default attribute becomes 15, and the screen
//   memory is swept to zero, one cell a cycle, during which s_axis_tready
//   stays low.
// Stall: the result waits in the output register; the next request is still
//   accepted and processed, and holds only its own finished result back
//   until the output register frees.
// ----------------------------------------------------------------------------
module text_console_writer import txcon_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // default_attribute
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code[7:0], attr_in[15:8],
                                      // col_in[22:16], row_in[27:23], zero
  input  logic [2:0]  s_axis_tuser,   // req_type[1:0], use_position[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cursor_pos[10:0], cell_char[18:11],
                                      // cell_attr[26:19], zero
);

  logic [ATTR_W-1:0] default_attribute;
  req_t              in_req;
  logic              done_valid;
  logic              done_ready;
  res_t              done_res;
  res_t              out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= DEFAULT_ATTR_RESET;
    end else if (cfg_we) begin
      default_attribute <= cfg_wdata;
    end
  end

  assign in_req.kind         = req_kind_t'(s_axis_tuser[1:0]);
  assign in_req.use_position = s_axis_tuser[2];
  assign in_req.char_code    = s_axis_tdata[7:0];
  assign in_req.attr_in      = s_axis_tdata[15:8];
  assign in_req.col_in       = s_axis_tdata[22:16];
  assign in_req.row_in       = s_axis_tdata[27:23];

  txcon_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .default_attribute (default_attribute),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_req            (in_req),
    .done_valid        (done_valid),
    .done_ready        (done_ready),
    .done_res          (done_res)
  );

  // Output register: the sequencer hands over as soon as it is empty or
  // being emptied.
  assign done_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_ready) begin
      m_axis_tvalid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_res <= done_res;
    end
  end

  assign m_axis_tdata = {5'd0, out_res.cell_attr, out_res.cell_char, out_res.cursor_pos};

endmodule
